### sv/vbpd_pkg.sv
`timescale 1ns / 1ps

package vbpd_pkg;

	// brick geometry
	localparam int VOXELS     = 512;
	localparam int PAL_SIZE   = 16;
	localparam int WORD_BITS  = 64;
	localparam int MASK_BYTES = VOXELS / 8;
	localparam int WORD_COUNT = VOXELS / WORD_BITS;
	localparam int VIDX_W     = $clog2(VOXELS);
	localparam int WSEL_W     = $clog2(WORD_COUNT);
	localparam int WOFS_W     = $clog2(WORD_BITS);
	localparam int MB_W       = $clog2(MASK_BYTES);
	localparam int PIDX_W     = $clog2(PAL_SIZE);
	localparam int PCNT_W     = PIDX_W + 1;
	localparam int POS_W      = $clog2(MASK_BYTES + VOXELS);

	// payload lengths per encoding
	localparam int LEN_UNIFORM  = 1;
	localparam int LEN_MASK     = MASK_BYTES + 1;
	localparam int LEN_PAL4     = MASK_BYTES + 1 + PAL_SIZE + VOXELS / 2;
	localparam int LEN_PAL8     = MASK_BYTES + VOXELS;
	localparam int PAL4_NIB_OFS = MASK_BYTES + 1 + PAL_SIZE;

	// command queue between front and back
	localparam int CMD_DEPTH = 4;
	localparam int CPTR_W    = $clog2(CMD_DEPTH);
	localparam int CCNT_W    = $clog2(CMD_DEPTH + 1);

	// encodings
	localparam logic [2:0] ENC_EMPTY   = 3'd0;
	localparam logic [2:0] ENC_UNIFORM = 3'd1;
	localparam logic [2:0] ENC_MASK    = 3'd2;
	localparam logic [2:0] ENC_PAL4    = 3'd3;
	localparam logic [2:0] ENC_PAL8    = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_VOXEL  = 2'd0;
	localparam logic [1:0] KIND_WORD   = 2'd1;
	localparam logic [1:0] KIND_WHOLE  = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_BAD_ENC = 3'd1;
	localparam logic [2:0] ERR_BAD_PAL = 3'd2;
	localparam logic [2:0] ERR_PAL_IDX = 3'd3;
	localparam logic [2:0] ERR_SHORT   = 3'd4;
	localparam logic [2:0] ERR_LONG    = 3'd5;

	typedef enum logic [1:0] {
		OP_STATUS,
		OP_WRITES,
		OP_WHOLE,
		OP_FILL
	} op_t;

	// one decoded payload byte, expanded by the back end into 1..8 items
	typedef struct packed {
		op_t               op;
		logic              two;
		logic [VIDX_W-1:0] idx0;
		logic [VIDX_W-1:0] idx1;
		logic [7:0]        mat0;
		logic [7:0]        mat1;
		logic [2:0]        err;
		logic              done;
	} cmd_t;

	// back end access to the occupancy mask for word fills
	typedef struct packed {
		logic [WSEL_W-1:0] word_sel;
		logic              done;
	} fill_port_t;

	function automatic logic [POS_W-1:0] last_pos(input logic [2:0] enc);
		logic [POS_W-1:0] r;
		case (enc)
			ENC_UNIFORM: r = POS_W'(LEN_UNIFORM - 1);
			ENC_MASK:    r = POS_W'(LEN_MASK - 1);
			ENC_PAL4:    r = POS_W'(LEN_PAL4 - 1);
			default:     r = POS_W'(LEN_PAL8 - 1);
		endcase
		return r;
	endfunction

endpackage

### sv/vbpd_cmd_fifo.sv
`timescale 1ns / 1ps

module vbpd_cmd_fifo import vbpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cmd_t              din,
	input  logic              pop,
	output cmd_t              dout,
	output logic              valid,
	output logic [CCNT_W-1:0] count
);

	cmd_t              mem_q [CMD_DEPTH];
	logic [CPTR_W-1:0] wr_ptr_q;
	logic [CPTR_W-1:0] rd_ptr_q;
	logic [CCNT_W-1:0] count_q;

	assign dout  = mem_q[rd_ptr_q];
	assign valid = (count_q != '0);
	assign count = count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == CPTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == CPTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= din;
	end

endmodule

### sv/vbpd_front.sv
`timescale 1ns / 1ps

module vbpd_front import vbpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_start,
	input  logic [2:0]        in_enc,
	input  logic              in_last,
	input  logic [CCNT_W-1:0] fifo_count,
	output logic              push,
	output cmd_t              push_cmd,
	input  fill_port_t        fill_port,
	output logic [63:0]       fill_word
);

	// brick state
	logic [POS_W-1:0]  pos_q;
	logic [2:0]        enc_q;
	logic              drop_q;
	logic [PCNT_W-1:0] pal_cnt_q;
	logic              fill_busy_q;
	logic [VOXELS-1:0] mask_q;
	logic [7:0]        pal_mem [PAL_SIZE];

	// decoded byte waiting for its palette reads
	logic              valid_s1;
	op_t               op_s1;
	logic              two_s1;
	logic [VIDX_W-1:0] idx0_s1;
	logic [VIDX_W-1:0] idx1_s1;
	logic [7:0]        byte_s1;
	logic              use_pal_s1;
	logic [2:0]        err_s1;
	logic              done_s1;
	logic [7:0]        pal_rd0_s1;
	logic [7:0]        pal_rd1_s1;

	logic              accept;
	logic              enc_ok;
	logic              act;
	logic [2:0]        e;
	logic [POS_W-1:0]  p;
	logic [POS_W-1:0]  pal4_ofs;
	logic [POS_W-1:0]  pal8_ofs;
	logic [POS_W-1:0]  pal_ofs;
	logic [VIDX_W-1:0] v0;
	logic [VIDX_W-1:0] v1;
	logic [VIDX_W-1:0] v8;
	logic [3:0]        nib_lo;
	logic [3:0]        nib_hi;
	logic              lo_occ;
	logic              hi_occ;
	logic              lo_bad;
	logic              hi_bad;
	logic              mask_wr;
	logic              pal_wr;
	logic              cnt_wr;
	logic              has_data;
	logic              two;
	logic              use_pal;
	logic [VIDX_W-1:0] idx0;
	logic [VIDX_W-1:0] idx1;
	logic [PIDX_W-1:0] nib_a;
	logic [PIDX_W-1:0] nib_b;
	logic [2:0]        err;
	logic              done;
	logic              emit;
	op_t               op;
	logic [POS_W-1:0]  pos_n;
	logic [2:0]        enc_n;
	logic              drop_n;

	// room for this item plus the one still in stage 1; stall while a word fill reads the mask
	assign in_ready = !fill_busy_q
		&& ((32'(fifo_count) + 32'(valid_s1)) < CMD_DEPTH);
	assign accept = in_valid && in_ready;

	assign fill_word = mask_q[{fill_port.word_sel, WOFS_W'(0)} +: WORD_BITS];

	// byte classification
	always_comb begin
		enc_ok   = (in_enc >= ENC_UNIFORM) && (in_enc <= ENC_PAL8);
		act      = 1'b0;
		err      = ERR_NONE;
		done     = 1'b0;
		e        = enc_q;
		p        = pos_q;
		pos_n    = pos_q;
		enc_n    = enc_q;
		drop_n   = drop_q;
		if (in_start) begin
			p      = '0;
			pos_n  = '0;
			drop_n = 1'b0;
			e      = in_enc;
			if (enc_ok) begin
				act   = 1'b1;
				enc_n = in_enc;
			end else begin
				err    = ERR_BAD_ENC;
				enc_n  = ENC_EMPTY;
				drop_n = 1'b1;
			end
		end else if (!drop_q && enc_q != ENC_EMPTY) begin
			act = 1'b1;
		end

		pal4_ofs = p - POS_W'(PAL4_NIB_OFS);
		pal8_ofs = p - POS_W'(MASK_BYTES);
		pal_ofs  = p - POS_W'(MASK_BYTES + 1);
		v0       = {pal4_ofs[VIDX_W-2:0], 1'b0};
		v1       = {pal4_ofs[VIDX_W-2:0], 1'b1};
		v8       = pal8_ofs[VIDX_W-1:0];
		nib_lo   = in_byte[3:0];
		nib_hi   = in_byte[7:4];
		lo_occ   = mask_q[v0];
		hi_occ   = mask_q[v1];
		lo_bad   = {1'b0, nib_lo} >= pal_cnt_q;
		hi_bad   = {1'b0, nib_hi} >= pal_cnt_q;

		mask_wr  = 1'b0;
		pal_wr   = 1'b0;
		cnt_wr   = 1'b0;
		has_data = 1'b0;
		two      = 1'b0;
		use_pal  = 1'b0;
		idx0     = '0;
		idx1     = '0;
		nib_a    = nib_lo;
		nib_b    = nib_hi;
		op       = OP_STATUS;

		if (act) begin
			pos_n = p + 1'b1;
			if (e == ENC_UNIFORM) begin
				op       = OP_WHOLE;
				has_data = 1'b1;
			end else if (p < POS_W'(MASK_BYTES)) begin
				mask_wr = 1'b1;
			end else begin
				case (e)
					ENC_MASK: begin
						op       = OP_FILL;
						has_data = 1'b1;
					end
					ENC_PAL4: begin
						if (p == POS_W'(MASK_BYTES)) begin
							if (in_byte == 8'd0 || 32'(in_byte) > PAL_SIZE)
								err = ERR_BAD_PAL;
							else
								cnt_wr = 1'b1;
						end else if (p <= POS_W'(MASK_BYTES + PAL_SIZE)) begin
							pal_wr = 1'b1;
						end else begin
							// two nibbles, low first; a bad occupied nibble stops the byte
							op      = OP_WRITES;
							use_pal = 1'b1;
							if (lo_occ && lo_bad) begin
								err = ERR_PAL_IDX;
							end else begin
								if (lo_occ) begin
									has_data = 1'b1;
									idx0     = v0;
								end
								if (hi_occ) begin
									if (hi_bad) begin
										err = ERR_PAL_IDX;
									end else if (lo_occ) begin
										two  = 1'b1;
										idx1 = v1;
									end else begin
										has_data = 1'b1;
										idx0     = v1;
										nib_a    = nib_hi;
									end
								end
							end
						end
					end
					default: begin
						op = OP_WRITES;
						if (mask_q[v8]) begin
							has_data = 1'b1;
							idx0     = v8;
						end
					end
				endcase
			end

			// end of brick checks
			if (err != ERR_NONE) begin
				enc_n  = ENC_EMPTY;
				drop_n = 1'b1;
			end else if (p == last_pos(e)) begin
				enc_n = ENC_EMPTY;
				if (in_last) begin
					done = 1'b1;
				end else begin
					err    = ERR_LONG;
					drop_n = 1'b1;
				end
			end else if (in_last) begin
				err   = ERR_SHORT;
				enc_n = ENC_EMPTY;
			end
		end

		if (!has_data)
			op = OP_STATUS;
		emit = has_data || (err != ERR_NONE) || done;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			enc_q       <= ENC_EMPTY;
			drop_q      <= 1'b0;
			pal_cnt_q   <= '0;
			fill_busy_q <= 1'b0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= accept && emit;
			if (accept) begin
				pos_q  <= pos_n;
				enc_q  <= enc_n;
				drop_q <= drop_n;
				if (cnt_wr)
					pal_cnt_q <= in_byte[PCNT_W-1:0];
			end
			if (accept && emit && op == OP_FILL)
				fill_busy_q <= 1'b1;
			else if (fill_port.done)
				fill_busy_q <= 1'b0;
		end
	end

	// mask, palette memory and stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (mask_wr)
				mask_q[{p[MB_W-1:0], 3'b000} +: 8] <= in_byte;
			if (pal_wr)
				pal_mem[pal_ofs[PIDX_W-1:0]] <= in_byte;
			pal_rd0_s1 <= pal_mem[nib_a];
			pal_rd1_s1 <= pal_mem[nib_b];
			op_s1      <= op;
			two_s1     <= two;
			idx0_s1    <= idx0;
			idx1_s1    <= idx1;
			byte_s1    <= in_byte;
			use_pal_s1 <= use_pal;
			err_s1     <= err;
			done_s1    <= done;
		end
	end

	// command assembly
	always_comb begin
		push          = valid_s1;
		push_cmd.op   = op_s1;
		push_cmd.two  = two_s1;
		push_cmd.idx0 = idx0_s1;
		push_cmd.idx1 = idx1_s1;
		push_cmd.mat0 = use_pal_s1 ? pal_rd0_s1 : byte_s1;
		push_cmd.mat1 = pal_rd1_s1;
		push_cmd.err  = err_s1;
		push_cmd.done = done_s1;
	end

endmodule

### sv/vbpd_back.sv
`timescale 1ns / 1ps

module vbpd_back import vbpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  cmd_t              head,
	output logic              pop,
	output fill_port_t        fill_port,
	input  logic [63:0]       fill_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_kind,
	output logic [VIDX_W-1:0] out_index,
	output logic [63:0]       out_mask,
	output logic [7:0]        out_material,
	output logic [2:0]        out_error,
	output logic              out_done,
	output logic              out_last
);

	logic [WSEL_W-1:0] sub_q;
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [VIDX_W-1:0] index_q;
	logic [63:0]       mask_q;
	logic [7:0]        mat_q;
	logic [2:0]        err_q;
	logic              done_q;
	logic              last_q;

	logic [WSEL_W-1:0] sub_last;
	logic              is_final;
	logic              load;
	logic [1:0]        kind;
	logic [VIDX_W-1:0] index;
	logic [63:0]       mask;
	logic [7:0]        mat;

	// expand the head command, one item per cycle while the output is not stalled
	always_comb begin
		case (head.op)
			OP_FILL:   sub_last = WSEL_W'(WORD_COUNT - 1);
			OP_WRITES: sub_last = head.two ? WSEL_W'(1) : '0;
			default:   sub_last = '0;
		endcase
		is_final = (sub_q == sub_last);
		load     = head_valid && (!out_valid_q || out_ready);
		pop      = load && is_final;

		fill_port.word_sel = sub_q;
		fill_port.done     = pop && (head.op == OP_FILL);

		kind  = KIND_STATUS;
		index = '0;
		mask  = '0;
		mat   = '0;
		case (head.op)
			OP_WHOLE: begin
				kind = KIND_WHOLE;
				mat  = head.mat0;
			end
			OP_FILL: begin
				kind  = KIND_WORD;
				index = {sub_q, WOFS_W'(0)};
				mask  = fill_word;
				mat   = head.mat0;
			end
			OP_WRITES: begin
				kind  = KIND_VOXEL;
				index = (sub_q != '0) ? head.idx1 : head.idx0;
				mat   = (sub_q != '0) ? head.mat1 : head.mat0;
			end
			default: begin
				kind = KIND_STATUS;
			end
		endcase
	end

	// item counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sub_q       <= is_final ? '0 : sub_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output register; status rides on the final item of the byte
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind;
			index_q <= index;
			mask_q  <= mask;
			mat_q   <= mat;
			err_q   <= is_final ? head.err : ERR_NONE;
			done_q  <= is_final && head.done;
			last_q  <= is_final;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = kind_q;
	assign out_index    = index_q;
	assign out_mask     = mask_q;
	assign out_material = mat_q;
	assign out_error    = err_q;
	assign out_done     = done_q;
	assign out_last     = last_q;

endmodule

### sv/voxel_brick_payload_decoder.sv
`timescale 1ns / 1ps

// Brick payload decoder: one payload byte per input item, zero or more
// voxel write items out.
// Input stream s_*: one byte per item; brick_start and encoding in tuser,
// the final payload byte marked by tlast.
// Output stream m_*: voxel writes, masked 64-voxel word fills, whole-brick
// fills or status-only items; tlast marks the last item caused by one byte,
// which also carries error_code and brick_done.
// The first item of a byte passes the stage 1 register, the command queue
// and the output register.
// Up to one byte per cycle is taken and one output item per cycle given,
// unless the queue is full, a word fill reads the mask or the receiver
// stalls. A byte that ends a mask-uniform brick gives 8 items; input is
// held off until those word fills have read the occupancy mask.
// A 4-entry command queue separates the decode front from the item back
// end, so a stalled receiver only stops input once the queue, counting the byte in stage 1, is full.
// Reset clears the brick state and empties the queue and output register;
// mask and palette contents are written by each brick before use.
module voxel_brick_payload_decoder import vbpd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // payload_byte
	input  logic [3:0]  s_tuser,  // brick_start, encoding[3:1]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // voxel_index, voxel_mask, material, error_code, brick_done, pad
	output logic [1:0]  m_tuser,  // kind
	output logic        m_tlast
);

	logic              push;
	cmd_t              push_cmd;
	logic              pop;
	cmd_t              head;
	logic              head_valid;
	logic [CCNT_W-1:0] fifo_count;
	fill_port_t        fill_port;
	logic [63:0]       fill_word;
	logic [VIDX_W-1:0] out_index;
	logic [63:0]       out_mask;
	logic [7:0]        out_material;
	logic [2:0]        out_error;
	logic              out_done;

	vbpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_start   (s_tuser[0]),
		.in_enc     (s_tuser[3:1]),
		.in_last    (s_tlast),
		.fifo_count (fifo_count),
		.push       (push),
		.push_cmd   (push_cmd),
		.fill_port  (fill_port),
		.fill_word  (fill_word)
	);

	vbpd_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.pop    (pop),
		.dout   (head),
		.valid  (head_valid),
		.count  (fifo_count)
	);

	vbpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.fill_port    (fill_port),
		.fill_word    (fill_word),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_kind     (m_tuser),
		.out_index    (out_index),
		.out_mask     (out_mask),
		.out_material (out_material),
		.out_error    (out_error),
		.out_done     (out_done),
		.out_last     (m_tlast)
	);

	assign m_tdata = {3'b000, out_done, out_error, out_material, out_mask, out_index};

endmodule
